### sv/usc_pkg.sv
// shared types and constants for the servo command decoder
package usc_pkg;

  localparam int unsigned ANGLE_DIGITS_DEF = 3;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned SERVO_W = 3;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned ANGLE_W = 11;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned STEP_W  = 6;

  localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE  = 8'h0A;
  localparam logic [BYTE_W-1:0] SP_BYTE  = 8'h20;
  localparam logic [BYTE_W-1:0] TAB_BYTE = 8'h09;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
  localparam logic [BYTE_W-1:0] CH_5     = 8'h35;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h61;

  localparam logic [ADDR_W-1:0]  PWM_BASE      = 7'h06;
  localparam logic [SERVO_W-1:0] SERVO_RST     = 3'd5;
  localparam logic [CFG_W-1:0]   PULSE_MIN_RST = 12'd110;
  localparam logic [CFG_W-1:0]   PULSE_MAX_RST = 12'd510;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MID  = 11'sd90;
  localparam logic signed [ANGLE_W-1:0] ANGLE_FULL = 11'sd180;
  localparam logic [ANGLE_W-1:0] PRESET_STEP = 11'd45;

  // x / 180 == (x * 5826) >> 20 for every x below 4096
  localparam logic [12:0]  RECIP_MUL   = 13'd5826;
  localparam int unsigned  RECIP_SHIFT = 20;

  localparam int unsigned CMD_DEPTH = 2;

  // configuration register indexes
  localparam logic CFG_PULSE_MIN = 1'b0;
  localparam logic CFG_PULSE_MAX = 1'b1;

  typedef struct packed {
    logic                      sweep;
    logic [SERVO_W-1:0]        channel;
    logic signed [ANGLE_W-1:0] angle;
  } cmd_t;

endpackage

### sv/usc_front.sv
// front end: byte decoding, mode tracking and angle parsing
module usc_front #(
  parameter int unsigned ANGLE_DIGITS = usc_pkg::ANGLE_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [usc_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                        cmd_push_o,
  output usc_pkg::cmd_t               cmd_o
);

  localparam int unsigned CNT_W = $clog2(ANGLE_DIGITS + 1);

  localparam logic [1:0] MODE_SELECT = 2'd0;
  localparam logic [1:0] MODE_PRESET = 2'd1;
  localparam logic [1:0] MODE_ANGLE  = 2'd2;

  logic [1:0]                   mode_q, mode_d;
  logic [usc_pkg::SERVO_W-1:0]  servo_q, servo_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [usc_pkg::BYTE_W-1:0]   digit_buf_q [ANGLE_DIGITS];
  logic [ANGLE_DIGITS-1:0][usc_pkg::BYTE_W-1:0] chars;
  logic                         buf_we;
  logic [2:0]                   preset_idx;
  logic [usc_pkg::BYTE_W-1:0]   d;

  function automatic logic is_digit(input logic [usc_pkg::BYTE_W-1:0] c);
    return (c >= usc_pkg::CH_0) && (c <= usc_pkg::CH_9);
  endfunction

  function automatic logic is_blank(input logic [usc_pkg::BYTE_W-1:0] c);
    return (c == usc_pkg::SP_BYTE) || ((c >= usc_pkg::TAB_BYTE) && (c <= usc_pkg::CR_BYTE));
  endfunction

  // atoi over the collected characters
  function automatic logic signed [usc_pkg::ANGLE_W-1:0] parse_angle(
    input logic [ANGLE_DIGITS-1:0][usc_pkg::BYTE_W-1:0] txt
  );
    logic       skipping;
    logic       done;
    logic       neg;
    logic [9:0] v;
    logic [usc_pkg::BYTE_W-1:0] c;
    skipping = 1'b1;
    done     = 1'b0;
    neg      = 1'b0;
    v        = '0;
    for (int i = 0; i < ANGLE_DIGITS; i++) begin
      c = txt[i];
      if (!done) begin
        if (skipping) begin
          if (is_blank(c)) begin
            skipping = 1'b1;
          end else if (c == usc_pkg::CH_PLUS || c == usc_pkg::CH_MINUS) begin
            neg      = (c == usc_pkg::CH_MINUS);
            skipping = 1'b0;
          end else if (is_digit(c)) begin
            v        = {6'd0, c[3:0]};
            skipping = 1'b0;
          end else begin
            done = 1'b1;
          end
        end else if (is_digit(c)) begin
          v = 10'(v * 10'd10) + {6'd0, c[3:0]};
        end else begin
          done = 1'b1;
        end
      end
    end
    return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  assign d = rx_byte_i;

  // buffer view with the current byte dropped into its slot
  always_comb begin
    for (int i = 0; i < ANGLE_DIGITS; i++) begin
      chars[i] = (cnt_q == CNT_W'(i)) ? d : digit_buf_q[i];
    end
  end

  assign preset_idx = d[2:0] - 3'd1;

  always_comb begin
    mode_d      = mode_q;
    servo_d     = servo_q;
    cnt_d       = cnt_q;
    buf_we      = 1'b0;
    cmd_push_o  = 1'b0;
    cmd_o.sweep   = 1'b0;
    cmd_o.channel = servo_q;
    cmd_o.angle   = '0;
    if (accept_i) begin
      unique case (mode_q)
        MODE_SELECT: begin
          mode_d = MODE_PRESET;
          if (d >= usc_pkg::CH_0 && d <= usc_pkg::CH_5) begin
            servo_d = d[2:0];
          end else if (d == usc_pkg::CR_BYTE || d == usc_pkg::LF_BYTE) begin
            cmd_push_o    = 1'b1;
            cmd_o.sweep   = 1'b1;
            cmd_o.channel = '0;
          end
        end
        MODE_PRESET: begin
          if (d >= usc_pkg::CH_1 && d <= usc_pkg::CH_5) begin
            cmd_push_o  = 1'b1;
            cmd_o.angle = $signed(11'({8'd0, preset_idx} * usc_pkg::PRESET_STEP));
          end else if (d == usc_pkg::CH_S) begin
            mode_d = MODE_SELECT;
          end else if (d == usc_pkg::CH_A) begin
            mode_d = MODE_ANGLE;
            cnt_d  = '0;
          end
        end
        MODE_ANGLE: begin
          if (cnt_q < CNT_W'(ANGLE_DIGITS)) begin
            buf_we = 1'b1;
            if (cnt_q == CNT_W'(ANGLE_DIGITS - 1)) begin
              cnt_d       = '0;
              cmd_push_o  = 1'b1;
              cmd_o.angle = parse_angle(chars);
            end else begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end else begin
            cnt_d = '0;
          end
          if (d == usc_pkg::CH_S) begin
            mode_d = MODE_SELECT;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SELECT;
      servo_q <= usc_pkg::SERVO_RST;
      cnt_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      servo_q <= servo_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ANGLE_DIGITS; i++) begin
      if (buf_we && cnt_q == CNT_W'(i)) begin
        digit_buf_q[i] <= d;
      end
    end
  end

endmodule

### sv/usc_cmd_fifo.sv
// short command queue between the decoder and the move generator
module usc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  usc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output usc_pkg::cmd_t cmd_o
);

  localparam int unsigned DEPTH = usc_pkg::CMD_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  usc_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### sv/usc_back.sv
// back end: pulse configuration, move expansion and result register
module usc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [usc_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               cmd_valid_i,
  input  usc_pkg::cmd_t                      cmd_i,
  output logic                               cmd_pop_o,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [usc_pkg::CHAN_W-1:0]         channel_o,
  output logic [usc_pkg::ADDR_W-1:0]         reg_address_o,
  output logic signed [usc_pkg::ANGLE_W-1:0] angle_value_o,
  output logic [usc_pkg::PULSE_W-1:0]        pulse_count_o,
  output logic                               last_o
);

  logic [usc_pkg::CFG_W-1:0]         pulse_min_q, pulse_max_q;
  logic signed [usc_pkg::STEP_W-1:0] step_q;
  logic signed [12:0]                diff;
  logic [11:0]                       diff_mag;
  logic [24:0]                       quot_full;
  logic [4:0]                        quot;

  logic [1:0]                        sub_q;
  logic                              out_valid_q;
  logic                              advance;
  logic                              fin;
  logic signed [usc_pkg::ANGLE_W-1:0] angle;
  logic signed [17:0]                prod;
  logic signed [17:0]                pulse;
  logic [usc_pkg::CHAN_W-1:0]        chan;

  // signed step = (max - min) / 180, truncated toward zero
  assign diff      = $signed({1'b0, pulse_max_q}) - $signed({1'b0, pulse_min_q});
  assign diff_mag  = diff[12] ? 12'(-diff) : diff[11:0];
  assign quot_full = {13'd0, diff_mag} * {12'd0, usc_pkg::RECIP_MUL};
  assign quot      = quot_full[usc_pkg::RECIP_SHIFT +: 5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_min_q <= usc_pkg::PULSE_MIN_RST;
      pulse_max_q <= usc_pkg::PULSE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        usc_pkg::CFG_PULSE_MIN: pulse_min_q <= cfg_wdata_i;
        usc_pkg::CFG_PULSE_MAX: pulse_max_q <= cfg_wdata_i;
        default: pulse_min_q <= pulse_min_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= diff[12] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  // a sweep expands into three moves, sub_q walks through them
  always_comb begin
    case (sub_q)
      2'd0:    angle = '0;
      2'd1:    angle = usc_pkg::ANGLE_MID;
      default: angle = usc_pkg::ANGLE_FULL;
    endcase
    if (!cmd_i.sweep) begin
      angle = cmd_i.angle;
    end
  end

  assign fin       = !cmd_i.sweep || (sub_q == 2'd2);
  assign advance   = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = advance && fin;
  assign chan      = {1'b0, cmd_i.channel};
  assign prod      = 18'(angle * step_q);
  assign pulse     = $signed({6'd0, pulse_min_q}) + prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        sub_q <= fin ? 2'd0 : sub_q + 2'd1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      channel_o     <= chan;
      reg_address_o <= usc_pkg::PWM_BASE + {1'b0, chan, 2'b00};
      angle_value_o <= angle;
      pulse_count_o <= pulse[usc_pkg::PULSE_W-1:0];
      last_o        <= fin;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

### sv/uart_servo_command_decoder.sv
// servo command decoder top level
//
// input channel: push_i / full_o carry one received serial byte per word on
// rx_byte_i. result channel: empty_o / pop_i carry one servo move per word:
// channel, PWM register address, angle, pulse count and a last flag that
// marks the final move caused by a byte.
// config: cfg_we_i writes pulse_min (index 0) or pulse_max (index 1) at once.
// a move passes through the command queue and then the result register before
// it reaches the result ports. throughput: one byte per cycle while full_o is
// low; a byte that causes one move or none keeps that rate, a line end in
// selection mode gives three moves, emitted one per cycle while results are popped.
// a two-entry command queue parts the decoder from the move generator, and
// the result register lets bytes keep coming while a move waits.
// when the receiver stops popping, the queue fills and full_o rises.
// reset: selection mode, servo 5 selected, pulse range 110..510, all queues
// empty.
module uart_servo_command_decoder #(
  parameter int unsigned ANGLE_DIGITS = usc_pkg::ANGLE_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [usc_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic [usc_pkg::BYTE_W-1:0]         rx_byte_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [usc_pkg::CHAN_W-1:0]         channel_o,
  output logic [usc_pkg::ADDR_W-1:0]         reg_address_o,
  output logic signed [usc_pkg::ANGLE_W-1:0] angle_value_o,
  output logic [usc_pkg::PULSE_W-1:0]        pulse_count_o,
  output logic                               last_o
);

  logic          accept;
  logic          cmd_push;
  usc_pkg::cmd_t cmd_in;
  logic          cmd_valid;
  usc_pkg::cmd_t cmd_head;
  logic          cmd_pop;

  assign accept = push_i && !full_o;

  usc_front #(
    .ANGLE_DIGITS(ANGLE_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  usc_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  usc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .channel_o     (channel_o),
    .reg_address_o (reg_address_o),
    .angle_value_o (angle_value_o),
    .pulse_count_o (pulse_count_o),
    .last_o        (last_o)
  );

endmodule
